### rtl/cses_pkg.sv
`default_nettype none
package cses_pkg;

    localparam int PAYLOAD_BYTES    = 8;
    localparam int FACTOR_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS    = 16;

    localparam int PAYLOAD_BITS = PAYLOAD_BYTES * 8;
    localparam int WORD_W       = 64;
    localparam int START_W      = 6;
    localparam int LENGTH_W     = 7;
    localparam int FACTOR_W     = 32;
    localparam int OFFSET_W     = 48;
    localparam int HALF_W       = WORD_W / 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = OFFSET_W;

    localparam int S_TDATA_W = WORD_W;
    localparam int M_TDATA_W = 3 * WORD_W;
    localparam int M_TUSER_W = 2;

    localparam logic [WORD_W-1:0] PAYLOAD_MASK =
        (PAYLOAD_BITS >= WORD_W) ? {WORD_W{1'b1}}
                                 : ~({WORD_W{1'b1}} << PAYLOAD_BITS);

    localparam logic [START_W-1:0]  START_RESET  = '0;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(1);
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(65536);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BIT     = 3'd0,
        CFG_SIGNAL_LENGTH = 3'd1,
        CFG_BYTE_ORDER    = 3'd2,
        CFG_SCALE_FACTOR  = 3'd3,
        CFG_SCALE_OFFSET  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        ORDER_INTEL    = 1'b0,
        ORDER_MOTOROLA = 1'b1
    } byte_order_t;

    typedef struct packed {
        logic [START_W-1:0]         start_bit;
        logic [LENGTH_W-1:0]        signal_length;
        byte_order_t                byte_order;
        logic signed [FACTOR_W-1:0] scale_factor;
        logic signed [OFFSET_W-1:0] scale_offset;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] raw_value;
        logic [WORD_W-1:0] signal_mask;
        logic              out_of_range;
    } ext_t;

    typedef struct packed {
        logic [WORD_W-1:0]        raw_value;
        logic [WORD_W-1:0]        signal_mask;
        logic signed [WORD_W-1:0] physical_value;
        logic                     saturated;
        logic                     out_of_range;
    } result_t;

    typedef struct packed {
        logic prod_en;
        logic sum_en;
        logic out_en;
    } scale_en_t;

    // Reverse the bit order inside each byte; maps a Motorola walk onto a
    // straight upward run.
    function automatic logic [WORD_W-1:0] byte_bit_swap(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = v[(i & ~7) | (7 - (i & 7))];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = v[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/cses_cfg.sv
`default_nettype none
module cses_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [cses_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cses_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cses_pkg::cfg_t                         cfg
);
    import cses_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_BIT:     cfg_next.start_bit     = cfg_data[START_W-1:0];
                CFG_SIGNAL_LENGTH: cfg_next.signal_length = cfg_data[LENGTH_W-1:0];
                CFG_BYTE_ORDER:    cfg_next.byte_order    = byte_order_t'(cfg_data[0]);
                CFG_SCALE_FACTOR:  cfg_next.scale_factor  = $signed(cfg_data[FACTOR_W-1:0]);
                CFG_SCALE_OFFSET:  cfg_next.scale_offset  = $signed(cfg_data[OFFSET_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_bit     <= START_RESET;
            cfg_reg.signal_length <= LENGTH_RESET;
            cfg_reg.byte_order    <= ORDER_INTEL;
            cfg_reg.scale_factor  <= $signed(FACTOR_RESET);
            cfg_reg.scale_offset  <= $signed(OFFSET_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### rtl/cses_extract.sv
`default_nettype none
module cses_extract (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic [cses_pkg::WORD_W-1:0]   payload,
    input  wire cses_pkg::cfg_t                cfg,
    output cses_pkg::ext_t                     ext
);
    import cses_pkg::*;

    logic                  motorola;
    logic [LENGTH_W-1:0]   len;
    logic [START_W-1:0]    walk_start;
    logic [WORD_W-1:0]     walk_word;
    logic [WORD_W-1:0]     len_mask;
    logic [WORD_W-1:0]     field;
    logic [WORD_W-1:0]     walk_mask;
    logic [LENGTH_W:0]     walk_end;
    logic [LENGTH_W-1:0]   rev_shift;
    ext_t                  ext_reg;
    ext_t                  ext_next;

    // In walk order, bit positions count up by one in both byte orders.
    always_comb begin
        motorola   = (cfg.byte_order == ORDER_MOTOROLA);
        len        = (cfg.signal_length > LENGTH_W'(WORD_W)) ? LENGTH_W'(WORD_W)
                                                             : cfg.signal_length;
        walk_start = motorola ? {cfg.start_bit[START_W-1:3], ~cfg.start_bit[2:0]}
                              : cfg.start_bit;
        walk_word  = motorola ? byte_bit_swap(payload) : payload;
        len_mask   = ~({WORD_W{1'b1}} << len);
        field      = (walk_word >> walk_start) & len_mask;
        walk_mask  = (len_mask << walk_start) & PAYLOAD_MASK;
        walk_end   = {2'b00, walk_start} + {1'b0, len};
        rev_shift  = LENGTH_W'(WORD_W) - len;

        ext_next.out_of_range = (walk_end > (LENGTH_W+1)'(PAYLOAD_BITS));
        ext_next.signal_mask  = motorola ? byte_bit_swap(walk_mask) : walk_mask;
        if (ext_next.out_of_range) begin
            ext_next.raw_value = '0;
        end else if (motorola) begin
            // first walked bit lands in the MSB
            ext_next.raw_value = bit_reverse(field) >> rev_shift;
        end else begin
            ext_next.raw_value = field;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ext_reg <= ext_next;
        end
    end

    assign ext = ext_reg;

endmodule
`default_nettype wire

### rtl/cses_scale.sv
`default_nettype none
module cses_scale (
    input  wire logic                                 aclk,
    input  wire cses_pkg::scale_en_t                  en,
    input  wire cses_pkg::ext_t                       ext,
    input  wire logic signed [cses_pkg::FACTOR_W-1:0] scale_factor,
    input  wire logic signed [cses_pkg::OFFSET_W-1:0] scale_offset,
    output cses_pkg::result_t                         result
);
    import cses_pkg::*;

    localparam int PART_W = HALF_W + 1 + FACTOR_W;
    localparam int PROD_W = WORD_W + FACTOR_W + 1;
    localparam int SHL    = (FACTOR_FRAC_BITS < OUT_FRAC_BITS)
                            ? OUT_FRAC_BITS - FACTOR_FRAC_BITS : 0;
    localparam int SHR    = (FACTOR_FRAC_BITS > OUT_FRAC_BITS)
                            ? FACTOR_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int SUM_W  = PROD_W + OUT_FRAC_BITS + 1;

    localparam logic [WORD_W-1:0] PHYS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] PHYS_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // stage: partial products
    ext_t                      p_ext_reg;
    logic signed [PART_W-1:0]  p_lo_reg;
    logic signed [PART_W-1:0]  p_hi_reg;
    logic signed [PART_W-1:0]  p_lo_next;
    logic signed [PART_W-1:0]  p_hi_next;

    // stage: full product
    ext_t                      s_ext_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;

    // stage: offset and clip
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   prod_adj;
    logic signed [SUM_W-1:0]   offset_ext;
    logic signed [SUM_W-1:0]   total;
    logic [SUM_W-WORD_W:0]     total_top;
    logic                      fits;
    result_t                   res_reg;
    result_t                   res_next;

    always_comb begin
        p_lo_next = $signed({1'b0, ext.raw_value[HALF_W-1:0]}) * scale_factor;
        p_hi_next = $signed({1'b0, ext.raw_value[WORD_W-1:HALF_W]}) * scale_factor;
    end

    always_comb begin
        prod_next = $signed({p_hi_reg, {HALF_W{1'b0}}})
                  + $signed({{(PROD_W-PART_W){p_lo_reg[PART_W-1]}}, p_lo_reg});
    end

    always_comb begin
        prod_ext   = $signed({{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});
        prod_adj   = (prod_ext <<< SHL) >>> SHR;
        offset_ext = $signed({{(SUM_W-OFFSET_W){scale_offset[OFFSET_W-1]}}, scale_offset});
        total      = prod_adj + offset_ext;
        total_top  = total[SUM_W-1:WORD_W-1];
        fits       = (&total_top) || !(|total_top);

        res_next.raw_value    = s_ext_reg.raw_value;
        res_next.signal_mask  = s_ext_reg.signal_mask;
        res_next.out_of_range = s_ext_reg.out_of_range;
        res_next.saturated    = !fits;
        if (fits) begin
            res_next.physical_value = total[WORD_W-1:0];
        end else if (total[SUM_W-1]) begin
            res_next.physical_value = PHYS_MIN;
        end else begin
            res_next.physical_value = PHYS_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            p_ext_reg <= ext;
            p_lo_reg  <= p_lo_next;
            p_hi_reg  <= p_hi_next;
        end
        if (en.sum_en) begin
            s_ext_reg <= p_ext_reg;
            prod_reg  <= prod_next;
        end
        if (en.out_en) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

### rtl/can_signal_extract_scale_unit.sv
`default_nettype none
// Extracts one signal from an 8-byte CAN payload (Intel or Motorola bit
// numbering, DBC style) and scales it to raw*factor+offset in Q47.16,
// clipped to signed 64 bits. One payload enters per cycle on the s_ side
// while s_tready is high, and one result per payload is offered on the m_
// side once the payload has passed through the registers listed below.
// It passes five registers: input register, extraction, two 33x32 partial
// products, product merge, then offset add and clip into the output
// register. The five stages advance independently, so a stalled output
// only holds the stages behind it once they fill up. Configuration writes
// are always taken and must be made while no payload is in flight.
module can_signal_extract_scale_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [cses_pkg::S_TDATA_W-1:0]    s_tdata,   // payload[63:0]
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // raw_value[63:0], signal_mask[127:64], physical_value[191:128]
    output      logic [cses_pkg::M_TDATA_W-1:0]    m_tdata,
    // saturated[0], out_of_range[1]
    output      logic [cses_pkg::M_TUSER_W-1:0]    m_tuser,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [cses_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cses_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cses_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    logic [STAGES:0]    stage_ready;
    logic [WORD_W-1:0]  payload_reg;
    cfg_t               cfg;
    ext_t               ext;
    result_t            result;
    scale_en_t          scale_en;

    // Each stage takes new data when it is empty or its contents move on.
    always_comb begin
        stage_ready[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next = valid_reg;
        if (stage_ready[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            payload_reg <= s_tdata;
        end
    end

    cses_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cses_extract u_extract (
        .aclk    (aclk),
        .load    (stage_ready[1]),
        .payload (payload_reg),
        .cfg     (cfg),
        .ext     (ext)
    );

    assign scale_en.prod_en = stage_ready[2];
    assign scale_en.sum_en  = stage_ready[3];
    assign scale_en.out_en  = stage_ready[4];

    cses_scale u_scale (
        .aclk         (aclk),
        .en           (scale_en),
        .ext          (ext),
        .scale_factor (cfg.scale_factor),
        .scale_offset (cfg.scale_offset),
        .result       (result)
    );

    assign s_tready  = stage_ready[0];
    assign m_tvalid  = valid_reg[STAGES-1];
    assign m_tdata   = {result.physical_value, result.signal_mask, result.raw_value};
    assign m_tuser   = {result.out_of_range, result.saturated};
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

### rtl/cses_port_chk.sv
`default_nettype none
module cses_port_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [191:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_oor_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[63:0] == 64'd0)
        else $error("out of range result with nonzero raw value");

    a_empty_mask_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[127:64] == 64'd0 |-> m_tdata[63:0] == 64'd0)
        else $error("raw value without covered payload bits");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[191:128] == 64'h8000_0000_0000_0000 ||
            m_tdata[191:128] == 64'h7FFF_FFFF_FFFF_FFFF)
        else $error("saturated result not at a limit");

endmodule

bind can_signal_extract_scale_unit cses_port_chk u_port_chk (.*);
`default_nettype wire
